// ===== src/ctb_pkg.sv =====
// Shared types and constants for the countdown timer bank.
`timescale 1ns / 1ps

package ctb_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int COUNT_WIDTH = 32;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LIM_W       = $clog2(NUM_SLOTS + 1);
    localparam int MASK_W      = 8;
    localparam int CFG_W       = 4;
    localparam int KIND_W      = 2;
    localparam int SLOT_FIELD_W = 3;
    localparam int LOAD_W      = 32;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_ARM  = 2'd1,
        KIND_STOP = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PENDING = 2'd1,
        MODE_ACTIVE  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } eng_state_t;

    typedef struct packed {
        kind_t                     kind;
        logic [SLOT_FIELD_W-1:0]   slot;
        logic [LOAD_W-1:0]         load_value;
    } cmd_t;

    typedef struct packed {
        logic [MASK_W-1:0] fired_mask;
        logic [MASK_W-1:0] active_mask;
    } result_t;

endpackage

// ===== src/ctb_count_ram.sv =====
// Count memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module ctb_count_ram (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [ctb_pkg::SLOT_W-1:0]      wr_addr,
    input  logic [ctb_pkg::COUNT_WIDTH-1:0] wr_data,
    input  logic [ctb_pkg::SLOT_W-1:0]      rd_addr,
    output logic [ctb_pkg::COUNT_WIDTH-1:0] rd_data
);
    import ctb_pkg::*;

    logic [COUNT_WIDTH-1:0] mem [NUM_SLOTS];
    logic [COUNT_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/ctb_engine.sv =====
// Slot walker: slot modes, tick sequencing and count read-modify-write.
`timescale 1ns / 1ps

module ctb_engine (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  ctb_pkg::cmd_t            cmd,
    input  logic [ctb_pkg::CFG_W-1:0] slots_in_use,
    output logic                     res_valid,
    input  logic                     res_ready,
    output ctb_pkg::result_t         res
);
    import ctb_pkg::*;

    eng_state_t              state_reg, state_next;
    logic [LIM_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                    wb_valid_reg, wb_valid_next;
    logic [SLOT_W-1:0]       wb_idx_reg, wb_idx_next;
    logic [NUM_SLOTS-1:0]    fired_reg, fired_next;
    mode_t                   mode_reg [NUM_SLOTS];
    mode_t                   mode_next [NUM_SLOTS];

    logic [LIM_W-1:0]        limit;
    logic                    slot_ok;
    logic [SLOT_W-1:0]       cmd_idx;
    logic                    ram_wr_en;
    logic [SLOT_W-1:0]       ram_wr_addr;
    logic [COUNT_WIDTH-1:0]  ram_wr_data;
    logic [COUNT_WIDTH-1:0]  ram_rd_data;
    logic [MASK_W-1:0]       fired_mask;
    logic [MASK_W-1:0]       active_mask;

    assign limit = (32'(slots_in_use) > NUM_SLOTS) ? LIM_W'(NUM_SLOTS) : LIM_W'(slots_in_use);
    assign slot_ok = 32'(cmd.slot) < NUM_SLOTS;
    assign cmd_idx = SLOT_W'(cmd.slot);

    ctb_count_ram u_count_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (rd_idx_reg[SLOT_W-1:0]),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_idx_reg   <= '0;
            wb_valid_reg <= 1'b0;
            wb_idx_reg   <= '0;
            fired_reg    <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                mode_reg[i] <= MODE_IDLE;
            end
        end
        else
        begin
            state_reg    <= state_next;
            rd_idx_reg   <= rd_idx_next;
            wb_valid_reg <= wb_valid_next;
            wb_idx_reg   <= wb_idx_next;
            fired_reg    <= fired_next;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                mode_reg[i] <= mode_next[i];
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        rd_idx_next   = rd_idx_reg;
        wb_valid_next = 1'b0;
        wb_idx_next   = wb_idx_reg;
        fired_next    = fired_reg;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            mode_next[i] = mode_reg[i];
        end
        ram_wr_en   = 1'b0;
        ram_wr_addr = wb_idx_reg;
        ram_wr_data = ram_rd_data - COUNT_WIDTH'(1);
        cmd_ready   = 1'b0;
        res_valid   = 1'b0;

        // Write back the slot read in the previous cycle.
        if (wb_valid_reg)
        begin
            unique case (mode_reg[wb_idx_reg])
                MODE_PENDING:
                begin
                    mode_next[wb_idx_reg] = MODE_ACTIVE;
                end
                MODE_ACTIVE:
                begin
                    if (ram_rd_data == '0)
                    begin
                        mode_next[wb_idx_reg]  = MODE_IDLE;
                        fired_next[wb_idx_reg] = 1'b1;
                    end
                    else
                    begin
                        ram_wr_en = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        KIND_TICK:
                        begin
                            rd_idx_next = '0;
                            fired_next  = '0;
                            state_next  = (limit == '0) ? ST_DONE : ST_WALK;
                        end
                        KIND_ARM:
                        begin
                            if (slot_ok)
                            begin
                                ram_wr_en          = 1'b1;
                                ram_wr_addr        = cmd_idx;
                                ram_wr_data        = cmd.load_value[COUNT_WIDTH-1:0];
                                mode_next[cmd_idx] = MODE_PENDING;
                            end
                        end
                        KIND_STOP:
                        begin
                            if (slot_ok)
                            begin
                                mode_next[cmd_idx] = MODE_IDLE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                wb_valid_next = 1'b1;
                wb_idx_next   = rd_idx_reg[SLOT_W-1:0];
                rd_idx_next   = rd_idx_reg + LIM_W'(1);
                if (rd_idx_next == limit)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fired_mask  = '0;
        active_mask = '0;
        for (int b = 0; b < MASK_W; b++)
        begin
            if (b < NUM_SLOTS)
            begin
                fired_mask[b]  = fired_reg[b];
                active_mask[b] = (mode_reg[b] == MODE_PENDING) || (mode_reg[b] == MODE_ACTIVE);
            end
        end
    end

    assign res.fired_mask  = fired_mask;
    assign res.active_mask = active_mask;

endmodule

// ===== src/countdown_timer_bank_core.sv =====
// Top level of the countdown timer bank: stream ports, config register, result register.
`timescale 1ns / 1ps

// Arm and stop items are handled in the idle state and give no result.
// A tick walks n = min(slots_in_use, NUM_SLOTS) slots through the count memory, one per cycle,
// then writes back the last slot in a drain state and offers the masks in a done state until
// the output register takes them (when n is zero it goes straight to the done state); the next
// item is taken once the walker is back in its idle state.
// Reset (rst_n low, async) idles all slots, zeroes slots_in_use; count memory is not cleared.

module countdown_timer_bank_core (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration: slots_in_use
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ctb_pkg::CFG_W-1:0]   cfg_data,
    // input items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [39:0]                 s_tdata,   // [2:0] slot, [34:3] load_value, rest zero
    input  logic [1:0]                  s_tuser,   // [1:0] kind
    // result items
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata    // [7:0] fired_mask, [15:8] active_mask
);
    import ctb_pkg::*;

    logic [CFG_W-1:0] slots_in_use_reg;
    logic             m_valid_reg, m_valid_next;
    result_t          m_data_reg, m_data_next;

    cmd_t             cmd;
    logic             res_valid;
    logic             res_ready;
    result_t          res;

    // Take a configuration write only while the walker idles and no item is offered,
    // so a walk never sees its slot count change.
    assign cfg_ready = s_tready && !s_tvalid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            slots_in_use_reg <= cfg_data;
        end
    end

    // Unpack the input item.
    assign cmd.kind       = kind_t'(s_tuser);
    assign cmd.slot       = s_tdata[2:0];
    assign cmd.load_value = s_tdata[34:3];

    ctb_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (s_tvalid),
        .cmd_ready    (s_tready),
        .cmd          (cmd),
        .slots_in_use (slots_in_use_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // Output register: take a new result once the old one has been taken or is
    // leaving in this cycle.
    assign res_ready = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload holds without reset.
    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_data_reg.active_mask, m_data_reg.fired_mask};

endmodule
